// File: design/rdf_statement_assembler_macros.svh
// Assertion macros for the statement assembler.
// Define ASSERT_OFF to compile the checks out.
`ifndef RDF_STATEMENT_ASSEMBLER_MACROS_SVH
`define RDF_STATEMENT_ASSEMBLER_MACROS_SVH

`ifndef ASSERT_OFF
// check that is switched off while reset is held
`define RSA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rsa: assertion failed");
// check that also watches reset itself
`define RSA_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rsa: assertion failed");
`else
`define RSA_ASSERT(label, clk, rstn, prop)
`define RSA_ASSERT_NORST(label, clk, prop)
`endif

`endif

// File: design/rsa_pkg.sv
package rsa_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int TERM_W          = 32;
    localparam int FRAME_W_DEF     = 4 + 4 * (2 + HANDLE_BITS_DEF);

    // grammar state held in each frame
    typedef enum logic [3:0] {
        ST_TOP = 4'd0,
        ST_S   = 4'd1,
        ST_P   = 4'd2,
        ST_O   = 4'd3,
        ST_Q   = 4'd4,
        ST_G   = 4'd5,
        ST_GS  = 4'd6,
        ST_GP  = 4'd7,
        ST_GO  = 4'd8,
        ST_BS  = 4'd9,
        ST_BP  = 4'd10,
        ST_BO  = 4'd11
    } pstate_t;

    // token kinds
    localparam logic [3:0] ACT_DIRECTIVE = 4'd0;
    localparam logic [3:0] ACT_IRI       = 4'd1;
    localparam logic [3:0] ACT_LITERAL   = 4'd2;
    localparam logic [3:0] ACT_LBRACE    = 4'd3;
    localparam logic [3:0] ACT_RBRACE    = 4'd4;
    localparam logic [3:0] ACT_LBRACK    = 4'd5;
    localparam logic [3:0] ACT_RBRACK    = 4'd6;
    localparam logic [3:0] ACT_DOT       = 4'd7;
    localparam logic [3:0] ACT_COMMA     = 4'd8;
    localparam logic [3:0] ACT_SEMI      = 4'd9;

    // stored term kinds
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_IRI   = 2'd1;
    localparam logic [1:0] K_LIT   = 2'd2;
    localparam logic [1:0] K_BLANK = 2'd3;

    // term slots of a frame
    localparam logic [1:0] SL_SUBJ = 2'd0;
    localparam logic [1:0] SL_PRED = 2'd1;
    localparam logic [1:0] SL_OBJ  = 2'd2;
    localparam logic [1:0] SL_GRPH = 2'd3;

    // result events
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_STMT      = 2'd1;
    localparam logic [1:0] EV_DIRECTIVE = 2'd2;
    localparam logic [1:0] EV_ERROR     = 2'd3;

    // object kind codes on the result
    localparam logic [1:0] OK_IRI   = 2'd0;
    localparam logic [1:0] OK_LIT   = 2'd1;
    localparam logic [1:0] OK_BLANK = 2'd2;

endpackage

// File: design/rsa_ram.sv
module rsa_ram
    import rsa_pkg::*;
#(
    parameter int WIDTH = FRAME_W_DEF,
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/rdf_statement_assembler.sv
// An accepted token beat passes the input register, then the result register, to its
// result beat; one token per cycle unless m_ready stalls; every token gives one result.
// The top frame lives in registers and is updated in one pass; parked frames sit in a
// RAM; read port plus push bypass hold the frame under the top, so a pop costs no bubble.
// Reset (aresetn, synchronous, active low) clears the stack pointer, top frame, error
// latch and sets the blank counter to 1; the frame RAM is not cleared.
`include "rdf_statement_assembler_macros.svh"

module rdf_statement_assembler
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_action,
    input  logic [TERM_W-1:0] s_term_id,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_event_res,
    output logic              m_subject_kind,
    output logic [TERM_W-1:0] m_subject_id,
    output logic [TERM_W-1:0] m_predicate_id,
    output logic [1:0]        m_object_kind,
    output logic [TERM_W-1:0] m_object_id,
    output logic              m_graph_valid,
    output logic [TERM_W-1:0] m_graph_id
);

    localparam int TOP_W    = $clog2(STACK_DEPTH);
    localparam int KIND_LSB = 4 * HANDLE_BITS;
    localparam int ST_LSB   = KIND_LSB + 8;
    localparam int FRAME_W  = ST_LSB + 4;

    // input stage
    logic                   in_vld_reg;
    logic [3:0]             in_act_reg;
    logic [TERM_W-1:0]      in_term_reg;

    // top frame and control
    pstate_t                     st_reg, st_next;
    logic [3:0][1:0]             kind_reg, kind_next;
    logic [3:0][HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [TOP_W-1:0]            top_reg, top_next, top_upd, rd_addr;
    logic [TERM_W-1:0]           blank_reg, blank_next;
    logic                        err_reg, err_next;

    // decode results
    logic                   ok, emit, dir, push, pop;
    logic [1:0]             slot;
    logic [HANDLE_BITS-1:0] hv;
    logic [FRAME_W-1:0]     wr_data, ram_q, below;
    logic [3:0][1:0]        wr_kind;
    logic [3:0][HANDLE_BITS-1:0] wr_hnd;
    logic                   ram_we;
    logic                   byp_vld_reg;
    logic [FRAME_W-1:0]     byp_data_reg;

    // result stage
    logic                   out_vld_reg;
    logic [1:0]             ev_reg, ev_c;
    logic                   skind_reg, skind_c;
    logic [TERM_W-1:0]      sid_reg, sid_c, pid_reg, pid_c, oid_reg, oid_c, gid_reg, gid_c;
    logic [1:0]             okind_reg, okind_c;
    logic                   gvld_reg, gvld_c;

    logic                   proc;

    assign proc    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || proc;
    assign hv      = HANDLE_BITS'(in_term_reg);
    assign below   = byp_vld_reg ? byp_data_reg : ram_q;

    // next frame, stack and error state
    always_comb begin
        st_next    = st_reg;
        kind_next  = kind_reg;
        hnd_next   = hnd_reg;
        top_next   = top_reg;
        blank_next = blank_reg;
        err_next   = err_reg;
        ok         = 1'b0;
        emit       = 1'b0;
        dir        = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        slot       = SL_SUBJ;
        wr_kind    = kind_reg;
        wr_hnd     = hnd_reg;
        wr_kind[SL_OBJ] = K_BLANK;
        wr_hnd[SL_OBJ]  = HANDLE_BITS'(blank_reg);
        wr_data    = {pstate_t'(4'(st_reg) + 4'd1), wr_kind, wr_hnd};

        if (!err_reg) begin
            case (in_act_reg)
                ACT_DIRECTIVE: begin
                    if (st_reg == ST_TOP || st_reg == ST_G) begin
                        ok  = 1'b1;
                        dir = 1'b1;
                    end
                end
                ACT_IRI: begin
                    unique case (st_reg)
                        ST_TOP, ST_G: begin
                            ok   = 1'b1;
                            slot = SL_SUBJ;
                        end
                        ST_S, ST_GS, ST_BS: begin
                            ok   = 1'b1;
                            slot = SL_PRED;
                        end
                        ST_P, ST_GP, ST_BP: begin
                            ok   = 1'b1;
                            slot = SL_OBJ;
                        end
                        ST_O: begin
                            ok   = 1'b1;
                            slot = SL_GRPH;
                        end
                        default: ok = 1'b0;
                    endcase
                    kind_next[slot] = K_IRI;
                    hnd_next[slot]  = hv;
                    st_next         = pstate_t'(4'(st_reg) + 4'd1);
                end
                ACT_LITERAL: begin
                    if (st_reg == ST_P || st_reg == ST_GP || st_reg == ST_BP) begin
                        ok                = 1'b1;
                        kind_next[SL_OBJ] = K_LIT;
                        hnd_next[SL_OBJ]  = hv;
                        st_next           = pstate_t'(4'(st_reg) + 4'd1);
                    end
                end
                ACT_LBRACE: begin
                    if (st_reg == ST_S) begin
                        ok                 = 1'b1;
                        kind_next[SL_GRPH] = kind_reg[SL_SUBJ];
                        hnd_next[SL_GRPH]  = hnd_reg[SL_SUBJ];
                        st_next            = ST_G;
                    end
                end
                ACT_RBRACE: begin
                    if (st_reg == ST_G || st_reg == ST_GO) begin
                        ok                 = 1'b1;
                        emit               = (st_reg == ST_GO);
                        kind_next[SL_GRPH] = K_NONE;
                        hnd_next[SL_GRPH]  = '0;
                        st_next            = ST_TOP;
                    end
                end
                ACT_LBRACK: begin
                    if ((st_reg == ST_P || st_reg == ST_GP || st_reg == ST_BP) &&
                        top_reg != TOP_W'(STACK_DEPTH - 1)) begin
                        ok                 = 1'b1;
                        push               = 1'b1;
                        st_next            = ST_BS;
                        kind_next[SL_SUBJ] = K_BLANK;
                        hnd_next[SL_SUBJ]  = HANDLE_BITS'(blank_reg);
                        kind_next[SL_PRED] = K_NONE;
                        hnd_next[SL_PRED]  = '0;
                        kind_next[SL_OBJ]  = K_NONE;
                        hnd_next[SL_OBJ]   = '0;
                        blank_next         = blank_reg + TERM_W'(1);
                        top_next           = top_reg + TOP_W'(1);
                    end
                end
                ACT_RBRACK: begin
                    if ((st_reg == ST_BO || st_reg == ST_BS) && top_reg != '0) begin
                        ok        = 1'b1;
                        pop       = 1'b1;
                        emit      = (st_reg == ST_BO);
                        st_next   = pstate_t'(below[ST_LSB +: 4]);
                        kind_next = below[KIND_LSB +: 8];
                        hnd_next  = below[KIND_LSB-1:0];
                        top_next  = top_reg - TOP_W'(1);
                    end
                end
                ACT_DOT: begin
                    if (st_reg == ST_O || st_reg == ST_Q) begin
                        ok                 = 1'b1;
                        emit               = 1'b1;
                        st_next            = ST_TOP;
                        kind_next[SL_GRPH] = K_NONE;
                        hnd_next[SL_GRPH]  = '0;
                    end else if (st_reg == ST_GO) begin
                        ok      = 1'b1;
                        emit    = 1'b1;
                        st_next = ST_G;
                    end
                end
                ACT_COMMA: begin
                    if (st_reg == ST_O || st_reg == ST_GO || st_reg == ST_BO) begin
                        ok      = 1'b1;
                        emit    = 1'b1;
                        st_next = pstate_t'(4'(st_reg) - 4'd1);
                    end
                end
                ACT_SEMI: begin
                    if (st_reg == ST_O || st_reg == ST_GO || st_reg == ST_BO) begin
                        ok      = 1'b1;
                        emit    = 1'b1;
                        st_next = pstate_t'(4'(st_reg) - 4'd2);
                    end
                end
                default: ok = 1'b0;
            endcase
        end

        // rejected token or latched error: nothing moves
        if (!ok) begin
            st_next    = st_reg;
            kind_next  = kind_reg;
            hnd_next   = hnd_reg;
            top_next   = top_reg;
            blank_next = blank_reg;
            err_next   = 1'b1;
            emit       = 1'b0;
            dir        = 1'b0;
            push       = 1'b0;
            pop        = 1'b0;
        end
    end

    // result fields
    always_comb begin
        ev_c    = EV_NONE;
        skind_c = 1'b0;
        sid_c   = '0;
        pid_c   = '0;
        okind_c = OK_IRI;
        oid_c   = '0;
        gvld_c  = 1'b0;
        gid_c   = '0;
        if (!ok) begin
            ev_c = EV_ERROR;
        end else if (dir) begin
            ev_c  = EV_DIRECTIVE;
            oid_c = TERM_W'(hv);
        end else if (emit) begin
            ev_c    = EV_STMT;
            skind_c = (kind_reg[SL_SUBJ] == K_BLANK);
            sid_c   = TERM_W'(hnd_reg[SL_SUBJ]);
            pid_c   = TERM_W'(hnd_reg[SL_PRED]);
            if (kind_reg[SL_OBJ] == K_LIT) begin
                okind_c = OK_LIT;
            end else if (kind_reg[SL_OBJ] == K_BLANK) begin
                okind_c = OK_BLANK;
            end
            oid_c = TERM_W'(hnd_reg[SL_OBJ]);
            if (kind_reg[SL_GRPH] != K_NONE) begin
                gvld_c = 1'b1;
                gid_c  = TERM_W'(hnd_reg[SL_GRPH]);
            end
        end
    end

    // RAM read port tracks the frame under the next top
    assign ram_we  = proc && push;
    assign top_upd = proc ? top_next : top_reg;
    assign rd_addr = top_upd - TOP_W'(1);

    rsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_frames (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (top_reg),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= ST_TOP;
            kind_reg    <= '0;
            hnd_reg     <= '0;
            top_reg     <= '0;
            blank_reg   <= TERM_W'(1);
            err_reg     <= 1'b0;
            byp_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (proc) begin
                out_vld_reg <= 1'b1;
                st_reg      <= st_next;
                kind_reg    <= kind_next;
                hnd_reg     <= hnd_next;
                top_reg     <= top_next;
                blank_reg   <= blank_next;
                err_reg     <= err_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            // write and read on the same entry: RAM returns old data, so forward
            byp_vld_reg <= ram_we && (top_reg == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= wr_data;
        if (s_valid && s_ready) begin
            in_act_reg  <= s_action;
            in_term_reg <= s_term_id;
        end
        if (proc) begin
            ev_reg    <= ev_c;
            skind_reg <= skind_c;
            sid_reg   <= sid_c;
            pid_reg   <= pid_c;
            okind_reg <= okind_c;
            oid_reg   <= oid_c;
            gvld_reg  <= gvld_c;
            gid_reg   <= gid_c;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_event_res    = ev_reg;
    assign m_subject_kind = skind_reg;
    assign m_subject_id   = sid_reg;
    assign m_predicate_id = pid_reg;
    assign m_object_kind  = okind_reg;
    assign m_object_id    = oid_reg;
    assign m_graph_valid  = gvld_reg;
    assign m_graph_id     = gid_reg;

    `RSA_ASSERT(a_err_sticky, aclk, aresetn, err_reg |=> err_reg)
    `RSA_ASSERT(a_err_out, aclk, aresetn, (m_valid && err_reg) |-> (m_event_res == EV_ERROR))
    `RSA_ASSERT(a_nested_blank, aclk, aresetn, (top_reg != '0) |-> (st_reg == ST_BS || st_reg == ST_BP || st_reg == ST_BO))
    `RSA_ASSERT(a_bottom_frame, aclk, aresetn, (top_reg == '0) |-> !(st_reg == ST_BS || st_reg == ST_BP || st_reg == ST_BO))
    `RSA_ASSERT_NORST(a_reset_clears, aclk, !aresetn |=> (!m_valid && !err_reg))

endmodule

// File: bench/rdf_statement_assembler_tb.sv
`timescale 1ns / 100ps

module rdf_statement_assembler_tb;
    import rsa_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int RANDOM_TOKS = 1880;
    localparam int TAIL_TOKS   = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]        ev;
        logic              skind;
        logic [TERM_W-1:0] sid;
        logic [TERM_W-1:0] pid;
        logic [1:0]        okind;
        logic [TERM_W-1:0] oid;
        logic              gv;
        logic [TERM_W-1:0] gid;
    } asm_event_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TERM_W-1:0] h;
    } held_term_t;

    typedef struct packed {
        logic [3:0]        act;
        logic [TERM_W-1:0] term;
        bit                pinned;
        logic [1:0]        exp_ev;
        logic [TERM_W-1:0] exp_oid;
    } script_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_action = ACT_DIRECTIVE;
    logic [TERM_W-1:0] s_term_id = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_event_res;
    logic              m_subject_kind;
    logic [TERM_W-1:0] m_subject_id;
    logic [TERM_W-1:0] m_predicate_id;
    logic [1:0]        m_object_kind;
    logic [TERM_W-1:0] m_object_id;
    logic              m_graph_valid;
    logic [TERM_W-1:0] m_graph_id;

    rdf_statement_assembler dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_term_id      (s_term_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_subject_kind (m_subject_kind),
        .m_subject_id   (m_subject_id),
        .m_predicate_id (m_predicate_id),
        .m_object_kind  (m_object_kind),
        .m_object_id    (m_object_id),
        .m_graph_valid  (m_graph_valid),
        .m_graph_id     (m_graph_id)
    );

    always #5 aclk = ~aclk;

    // shadow of the parser stack
    pstate_t           frame_st [DEPTH];
    held_term_t        frame_term [DEPTH][4];
    int unsigned       depth_ptr;
    logic [TERM_W-1:0] next_blank;
    bit                latched;

    asm_event_t events_due[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    int         rx_left = 0;
    int         rx_mode = 0;
    bit         pin_on = 1'b0;
    asm_event_t pin_event = '0;

    function automatic bit expects_object(logic [3:0] s);
        return s == ST_P || s == ST_GP || s == ST_BP;
    endfunction

    function automatic bit token_legal(logic [3:0] s, int unsigned dp, logic [3:0] a);
        case (a)
            ACT_DIRECTIVE: return s == ST_TOP || s == ST_G;
            ACT_IRI:       return s <= ST_O || (s >= ST_G && s <= ST_GP) ||
                                  s == ST_BS || s == ST_BP;
            ACT_LITERAL:   return expects_object(s);
            ACT_LBRACE:    return s == ST_S;
            ACT_RBRACE:    return s == ST_G || s == ST_GO;
            ACT_LBRACK:    return expects_object(s) && dp + 1 < DEPTH;
            ACT_RBRACK:    return (s == ST_BO || s == ST_BS) && dp > 0;
            ACT_DOT:       return s == ST_O || s == ST_Q || s == ST_GO;
            ACT_COMMA,
            ACT_SEMI:      return s == ST_O || s == ST_GO || s == ST_BO;
            default:       return 1'b0;
        endcase
    endfunction

    // shortest way down the stack: push wherever an object is wanted
    function automatic logic [3:0] dive_action(logic [3:0] s);
        case (s)
            ST_P, ST_GP, ST_BP: return ACT_LBRACK;
            ST_O, ST_GO, ST_BO: return ACT_COMMA;
            ST_Q:               return ACT_DOT;
            default:            return ACT_IRI;
        endcase
    endfunction

    function automatic logic [TERM_W-1:0] rand_term();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return TERM_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic asm_event_t statement_of(int unsigned f);
        asm_event_t e;
        e       = '0;
        e.ev    = EV_STMT;
        e.skind = frame_term[f][SL_SUBJ].kind == K_BLANK;
        e.sid   = frame_term[f][SL_SUBJ].h;
        e.pid   = frame_term[f][SL_PRED].h;
        case (frame_term[f][SL_OBJ].kind)
            K_LIT:   e.okind = OK_LIT;
            K_BLANK: e.okind = OK_BLANK;
            default: e.okind = OK_IRI;
        endcase
        e.oid = frame_term[f][SL_OBJ].h;
        if (frame_term[f][SL_GRPH].kind != K_NONE) begin
            e.gv  = 1'b1;
            e.gid = frame_term[f][SL_GRPH].h;
        end
        return e;
    endfunction

    function automatic asm_event_t assemble_token(logic [3:0] act, logic [TERM_W-1:0] h);
        asm_event_t e;
        logic [3:0] s;
        logic [3:0] slot;
        bit         ok;
        bit         emit;
        e    = '0;
        ok   = 1'b0;
        emit = 1'b0;
        slot = '0;
        if (latched) begin
            e.ev = EV_ERROR;
            return e;
        end
        s = frame_st[depth_ptr];
        case (act)
            ACT_DIRECTIVE: begin
                if (s == ST_TOP || s == ST_G) begin
                    e.ev  = EV_DIRECTIVE;
                    e.oid = h;
                    ok    = 1'b1;
                end
            end
            ACT_IRI: begin
                ok = 1'b1;
                if (s <= ST_O) begin
                    slot = s;   // an IRI after the object is the quad's graph term
                end else if (s >= ST_G && s <= ST_GP) begin
                    slot = s - ST_G;
                end else if (s == ST_BS || s == ST_BP) begin
                    slot = s - ST_BS + 4'd1;
                end else begin
                    ok = 1'b0;
                end
                if (ok) begin
                    frame_term[depth_ptr][slot[1:0]] = '{K_IRI, h};
                    s = s + 4'd1;
                end
            end
            ACT_LITERAL: begin
                if (expects_object(s)) begin
                    frame_term[depth_ptr][SL_OBJ] = '{K_LIT, h};
                    s  = s + 4'd1;
                    ok = 1'b1;
                end
            end
            ACT_LBRACE: begin
                if (s == ST_S) begin
                    frame_term[depth_ptr][SL_GRPH] = frame_term[depth_ptr][SL_SUBJ];
                    s  = ST_G;
                    ok = 1'b1;
                end
            end
            ACT_RBRACE: begin
                if (s == ST_GO) begin
                    e = statement_of(depth_ptr);
                end
                if (s == ST_G || s == ST_GO) begin
                    frame_term[depth_ptr][SL_GRPH] = '{K_NONE, '0};
                    s  = ST_TOP;
                    ok = 1'b1;
                end
            end
            ACT_LBRACK: begin
                if (expects_object(s) && depth_ptr + 1 < DEPTH) begin
                    frame_term[depth_ptr][SL_OBJ] = '{K_BLANK, next_blank};
                    next_blank = next_blank + TERM_W'(1);
                    frame_st[depth_ptr] = pstate_t'(s + 4'd1);
                    frame_term[depth_ptr + 1][SL_SUBJ] = frame_term[depth_ptr][SL_OBJ];
                    frame_term[depth_ptr + 1][SL_PRED] = '0;
                    frame_term[depth_ptr + 1][SL_OBJ]  = '0;
                    frame_term[depth_ptr + 1][SL_GRPH] = frame_term[depth_ptr][SL_GRPH];
                    frame_st[depth_ptr + 1] = ST_BS;
                    depth_ptr = depth_ptr + 1;
                    return e;
                end
            end
            ACT_RBRACK: begin
                if ((s == ST_BO || s == ST_BS) && depth_ptr > 0) begin
                    if (s == ST_BO) begin
                        e = statement_of(depth_ptr);
                    end
                    depth_ptr = depth_ptr - 1;
                    return e;
                end
            end
            ACT_DOT: begin
                if (s == ST_O || s == ST_Q) begin
                    s    = ST_TOP;
                    ok   = 1'b1;
                    emit = 1'b1;
                end else if (s == ST_GO) begin
                    s    = ST_G;
                    ok   = 1'b1;
                    emit = 1'b1;
                end
            end
            ACT_COMMA: begin
                if (s == ST_O || s == ST_GO || s == ST_BO) begin
                    s    = s - 4'd1;
                    ok   = 1'b1;
                    emit = 1'b1;
                end
            end
            ACT_SEMI: begin
                if (s == ST_O || s == ST_GO || s == ST_BO) begin
                    s    = s - 4'd2;
                    ok   = 1'b1;
                    emit = 1'b1;
                end
            end
            default: ;
        endcase
        if (!ok) begin
            latched = 1'b1;
            e       = '0;
            e.ev    = EV_ERROR;
            return e;
        end
        if (emit) begin
            e = statement_of(depth_ptr);
            if (s == ST_TOP) begin
                frame_term[depth_ptr][SL_GRPH] = '{K_NONE, '0};
            end
        end
        frame_st[depth_ptr] = pstate_t'(s);
        return e;
    endfunction

    task automatic report_miss(string what, logic [TERM_W-1:0] got, logic [TERM_W-1:0] want);
        mismatches++;
        $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic check_event(asm_event_t got, asm_event_t want);
        if (got.ev !== want.ev)
            report_miss("event_res", TERM_W'(got.ev), TERM_W'(want.ev));
        if (got.skind !== want.skind)
            report_miss("subject_kind", TERM_W'(got.skind), TERM_W'(want.skind));
        if (got.sid !== want.sid)     report_miss("subject_id", got.sid, want.sid);
        if (got.pid !== want.pid)     report_miss("predicate_id", got.pid, want.pid);
        if (got.okind !== want.okind)
            report_miss("object_kind", TERM_W'(got.okind), TERM_W'(want.okind));
        if (got.oid !== want.oid)     report_miss("object_id", got.oid, want.oid);
        if (got.gv !== want.gv)
            report_miss("graph_valid", TERM_W'(got.gv), TERM_W'(want.gv));
        if (got.gid !== want.gid)     report_miss("graph_id", got.gid, want.gid);
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_token(logic [3:0] act, logic [TERM_W-1:0] term, bit pinned,
                              asm_event_t pinned_ev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_term_id <= term;
        pin_on    <= pinned;
        pin_event <= pinned_ev;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 3) != 0;
            2:       m_ready <= $urandom_range(0, 3) == 0;
            default: m_ready <= rx_left[2];
        endcase
    end

    always @(posedge aclk) begin
        asm_event_t got;
        if (aresetn && s_valid && s_ready) begin
            got = assemble_token(s_action, s_term_id);
            events_due.push_back(pin_on ? pin_event : got);
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_event_res, m_subject_kind, m_subject_id, m_predicate_id,
                    m_object_kind, m_object_id, m_graph_valid, m_graph_id};
            if (events_due.size() == 0) begin
                report_miss("unexpected result beat, event_res", TERM_W'(got.ev), '0);
            end else begin
                check_event(got, events_due.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** rdf_statement_assembler: FAILED **");
            $finish;
        end
    end

    initial begin
        script_row_t opening [26];
        asm_event_t  pinned_ev;
        logic [3:0]  a;
        bit          dive;
        int          kind;

        for (int i = 0; i < DEPTH; i++) begin
            frame_st[i] = ST_TOP;
            for (int j = 0; j < 4; j++) frame_term[i][j] = '0;
        end
        depth_ptr  = 0;
        next_blank = 1;
        latched    = 1'b0;

        opening = '{
            '{ACT_DIRECTIVE, 32'h0000_0000, 1'b1, EV_DIRECTIVE, 32'h0000_0000},
            '{ACT_DIRECTIVE, 32'hFFFF_FFFF, 1'b1, EV_DIRECTIVE, 32'hFFFF_FFFF},
            '{ACT_IRI,       32'hFFFF_FFFF, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_LITERAL,   32'hA5A5_A5A5, 1'b1, EV_NONE,      32'h0},
            '{ACT_COMMA,     32'hFFFF_FFFF, 1'b0, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h5A5A_5A5A, 1'b1, EV_NONE,      32'h0},
            '{ACT_SEMI,      32'h0000_0000, 1'b0, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0011, 1'b1, EV_NONE,      32'h0},
            '{ACT_LBRACK,    32'h0000_0022, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0033, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0044, 1'b1, EV_NONE,      32'h0},
            '{ACT_RBRACK,    32'h0000_0000, 1'b0, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0055, 1'b1, EV_NONE,      32'h0},
            '{ACT_DOT,       32'h0000_0000, 1'b0, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0066, 1'b1, EV_NONE,      32'h0},
            '{ACT_LBRACE,    32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_DIRECTIVE, 32'h0000_0077, 1'b1, EV_DIRECTIVE, 32'h0000_0077},
            '{ACT_RBRACE,    32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0088, 1'b1, EV_NONE,      32'h0},
            '{ACT_LBRACE,    32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_0099, 1'b1, EV_NONE,      32'h0},
            '{ACT_IRI,       32'h0000_00AA, 1'b1, EV_NONE,      32'h0},
            '{ACT_LBRACK,    32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_RBRACK,    32'h0000_0000, 1'b1, EV_NONE,      32'h0},
            '{ACT_RBRACE,    32'h0000_0000, 1'b0, EV_NONE,      32'h0}
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // nested blank node, quad, empty graph, brace closing a pending object
        foreach (opening[i]) begin
            pinned_ev     = '0;
            pinned_ev.ev  = opening[i].exp_ev;
            pinned_ev.oid = opening[i].exp_oid;
            send_token(opening[i].act, opening[i].term, opening[i].pinned, pinned_ev);
        end

        // well-formed token streams; the occasional dive fills the stack
        dive = 1'b0;
        for (int n = 0; n < RANDOM_TOKS; n++) begin
            if (!dive && $urandom_range(0, 199) == 0) dive = 1'b1;
            if (depth_ptr == DEPTH - 1) dive = 1'b0;
            if (dive) begin
                a = dive_action(frame_st[depth_ptr]);
            end else begin
                do a = 4'($urandom_range(0, 9));
                while (!token_legal(frame_st[depth_ptr], depth_ptr, a));
            end
            send_token(a, rand_term(), 1'b0, '0);
        end

        // errors latch until reset, so the broken beat follows the legal streams; only tail tokens come after it
        kind = $urandom_range(0, 2);
        if (kind == 0) begin
            send_token(4'($urandom_range(10, 15)), rand_term(), 1'b0, '0);
        end else if (kind == 1) begin
            do a = 4'($urandom_range(0, 9));
            while (token_legal(frame_st[depth_ptr], depth_ptr, a));
            send_token(a, rand_term(), 1'b0, '0);
        end else begin
            while (!(depth_ptr == DEPTH - 1 && expects_object(frame_st[depth_ptr]))) begin
                send_token(dive_action(frame_st[depth_ptr]), rand_term(), 1'b0, '0);
            end
            send_token(ACT_LBRACK, rand_term(), 1'b0, '0);
        end
        for (int n = 0; n < TAIL_TOKS; n++) begin
            send_token(4'($urandom_range(0, 15)), rand_term(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (events_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** rdf_statement_assembler: PASSED **");
        end else begin
            $display("** rdf_statement_assembler: FAILED **");
        end
        $finish;
    end

endmodule
